// ===== hw/rtl/script_bytecode_operand_walker_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bytecode operand walker
// Shared helpers that bind each check to the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_BYTECODE_OPERAND_WALKER_CORE_DEFINES_SVH
`define SCRIPT_BYTECODE_OPERAND_WALKER_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define SBOW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SBOW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sbow_pkg.sv =====
// ----------------------------------------------------------------------------
// Bytecode operand walker package
// Operand format table, mode and role codes, and the walker state types.
// ----------------------------------------------------------------------------
`default_nettype none

package sbow_pkg;

    // Operand modes: what the next byte of the stream is.
    localparam logic [2:0] MODE_OPCODE = 3'd0;
    localparam logic [2:0] MODE_IMM    = 3'd1;
    localparam logic [2:0] MODE_EXPR   = 3'd2;
    localparam logic [2:0] MODE_TOKARG = 3'd3;
    localparam logic [2:0] MODE_OFFSET = 3'd4;
    localparam logic [2:0] MODE_SEP    = 3'd5;
    localparam logic [2:0] MODE_TAG    = 3'd6;
    localparam logic [2:0] MODE_STR    = 3'd7;

    // List context.
    localparam logic [1:0] LIST_NONE = 2'd0;
    localparam logic [1:0] LIST_ONE  = 2'd1;
    localparam logic [1:0] LIST_TWO  = 2'd2;

    // Byte roles.
    localparam logic [2:0] ROLE_OPCODE   = 3'd0;
    localparam logic [2:0] ROLE_IMM      = 3'd1;
    localparam logic [2:0] ROLE_EXPR     = 3'd2;
    localparam logic [2:0] ROLE_EXPR_END = 3'd3;
    localparam logic [2:0] ROLE_TAG      = 3'd4;
    localparam logic [2:0] ROLE_STR_CHAR = 3'd5;
    localparam logic [2:0] ROLE_STR_END  = 3'd6;
    localparam logic [2:0] ROLE_OFFSET   = 3'd7;

    // Error codes.
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_OPCODE  = 3'd1;
    localparam logic [2:0] ERR_SEP     = 3'd2;
    localparam logic [2:0] ERR_TAG     = 3'd3;
    localparam logic [2:0] ERR_TRUNC   = 3'd4;

    // Operand format nibbles.
    localparam logic [3:0] NIB_U8     = 4'd1;
    localparam logic [3:0] NIB_U16    = 4'd2;
    localparam logic [3:0] NIB_U32    = 4'd3;
    localparam logic [3:0] NIB_EXPR   = 4'd4;
    localparam logic [3:0] NIB_OFFSET = 4'd5;
    localparam logic [3:0] NIB_LIST1  = 4'd6;
    localparam logic [3:0] NIB_LIST2  = 4'd7;
    localparam logic [3:0] NIB_STR    = 4'd8;

    // Format queues, next format in the low nibble.
    localparam logic [11:0] FMT_NONE          = 12'h000;
    localparam logic [11:0] FMT_U8            = 12'h001;
    localparam logic [11:0] FMT_U32           = 12'h003;
    localparam logic [11:0] FMT_OFFS          = 12'h005;
    localparam logic [11:0] FMT_LIST2         = 12'h007;
    localparam logic [11:0] FMT_STR           = 12'h008;
    localparam logic [11:0] FMT_UNKNOWN       = 12'h009;
    localparam logic [11:0] FMT_EXPR_OFFS     = 12'h054;
    localparam logic [11:0] FMT_LIST2_OFFS    = 12'h057;
    localparam logic [11:0] FMT_U8_LIST1      = 12'h061;
    localparam logic [11:0] FMT_U16_LIST1     = 12'h062;
    localparam logic [11:0] FMT_EXPR_LIST1    = 12'h064;
    localparam logic [11:0] FMT_EXPR_LIST2    = 12'h074;
    localparam logic [11:0] FMT_EXPR_LIST1_U8 = 12'h614;

    // Special stream bytes.
    localparam logic [7:0] BYTE_EXPR_END = 8'hFF;

    // Walker state.
    typedef struct packed {
        logic [31:0] position;
        logic [11:0] fmt_queue;
        logic [2:0]  mode;
        logic [2:0]  bytes_left;
        logic [31:0] offset_accum;
        logic [1:0]  list_ctx;
    } t_state;

    localparam t_state STATE_RESET = '{
        position:     32'd0,
        fmt_queue:    FMT_NONE,
        mode:         MODE_OPCODE,
        bytes_left:   3'd0,
        offset_accum: 32'd0,
        list_ctx:     LIST_NONE
    };

    // One result transaction.
    typedef struct packed {
        logic [31:0] byte_position;
        logic [2:0]  byte_role;
        logic        instruction_end;
        logic        offset_done;
        logic [31:0] offset_target;
        logic [2:0]  error_code;
    } t_result;

    // Opcode to operand format queue.
    function automatic logic [11:0] opcode_formats(input logic [7:0] op);
        logic [11:0] fm;
        case (op)
            8'h00:                                     fm = FMT_NONE;
            8'h13:                                     fm = FMT_U8;
            8'h01:                                     fm = FMT_STR;
            8'h04, 8'h16:                              fm = FMT_U8_LIST1;
            8'h03, 8'h09:                              fm = FMT_U16_LIST1;
            8'h05:                                     fm = FMT_EXPR_LIST1;
            8'h06, 8'h07, 8'h08:                       fm = FMT_EXPR_LIST1_U8;
            8'h0B, 8'h14, 8'h1C:                       fm = FMT_EXPR_OFFS;
            8'h10:                                     fm = FMT_LIST2_OFFS;
            8'h0C:                                     fm = FMT_OFFS;
            8'h0D:                                     fm = FMT_EXPR_LIST2;
            8'h0E, 8'h0F, 8'h11, 8'h12, 8'h15, 8'h1B, 8'h1D: fm = FMT_LIST2;
            8'h17, 8'h1F:                              fm = FMT_U32;
            default:                                   fm = FMT_UNKNOWN;
        endcase
        return fm;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sbow_step.sv =====
// ----------------------------------------------------------------------------
// Bytecode operand walker step
// Combinational update of the walker state for one byte, with its result.
// ----------------------------------------------------------------------------
`default_nettype none

module sbow_step
    import sbow_pkg::*;
(
    input  wire t_state      i_state,
    input  wire logic [7:0]  i_code_byte,
    input  wire logic        i_last_byte,
    output t_state           o_state,
    output t_result          o_result
);

    t_state      n_st;
    t_result     res;
    logic        advance;
    logic        iend;
    logic [11:0] fm;
    logic [3:0]  nib;
    logic [1:0]  byte_idx;
    logic [31:0] accum_next;

    assign fm         = opcode_formats(i_code_byte);
    assign byte_idx   = 2'(3'd4 - i_state.bytes_left);
    assign accum_next = i_state.offset_accum | ({24'd0, i_code_byte} << {byte_idx, 3'b000});

    always_comb begin
        n_st          = i_state;
        n_st.position = i_state.position + 32'd1;
        advance       = 1'b0;
        iend          = 1'b0;
        nib           = 4'd0;

        res                 = '0;
        res.byte_position   = i_state.position;
        res.byte_role       = ROLE_OPCODE;
        res.error_code      = ERR_NONE;

        // Byte handling for the current operand mode.
        case (i_state.mode)
            MODE_IMM: begin
                res.byte_role = ROLE_IMM;
                if (i_state.bytes_left > 3'd1) begin
                    n_st.bytes_left = i_state.bytes_left - 3'd1;
                end else begin
                    n_st.bytes_left = 3'd0;
                    advance         = 1'b1;
                end
            end
            MODE_EXPR: begin
                if (i_code_byte == BYTE_EXPR_END) begin
                    res.byte_role = ROLE_EXPR_END;
                    if (i_state.list_ctx == LIST_ONE) begin
                        n_st.mode = MODE_SEP;
                    end else if (i_state.list_ctx == LIST_TWO) begin
                        n_st.mode = MODE_TAG;
                    end else begin
                        advance = 1'b1;
                    end
                end else begin
                    res.byte_role = ROLE_EXPR;
                    if (i_code_byte inside {8'h80, 8'hA0, 8'hC0, 8'hF8, 8'hF9}) begin
                        n_st.bytes_left = 3'd1;
                        n_st.mode       = MODE_TOKARG;
                    end else if (i_code_byte inside {8'hF1, 8'hF3, 8'hF6}) begin
                        n_st.bytes_left = 3'd2;
                        n_st.mode       = MODE_TOKARG;
                    end else if (i_code_byte == 8'hF2) begin
                        n_st.bytes_left = 3'd4;
                        n_st.mode       = MODE_TOKARG;
                    end
                end
            end
            MODE_TOKARG: begin
                res.byte_role = ROLE_EXPR;
                if (i_state.bytes_left > 3'd1) begin
                    n_st.bytes_left = i_state.bytes_left - 3'd1;
                end else begin
                    n_st.bytes_left = 3'd0;
                    n_st.mode       = MODE_EXPR;
                end
            end
            MODE_OFFSET: begin
                res.byte_role     = ROLE_OFFSET;
                n_st.offset_accum = accum_next;
                if (i_state.bytes_left > 3'd1) begin
                    n_st.bytes_left = i_state.bytes_left - 3'd1;
                end else begin
                    n_st.bytes_left   = 3'd0;
                    res.offset_done   = 1'b1;
                    res.offset_target = accum_next;
                    advance           = 1'b1;
                end
            end
            MODE_SEP: begin
                res.byte_role = ROLE_TAG;
                if (i_code_byte >= 8'd2) begin
                    res.error_code = ERR_SEP;
                end
                if (i_code_byte != 8'd0) begin
                    n_st.mode = MODE_EXPR;
                end else begin
                    n_st.list_ctx = LIST_NONE;
                    advance       = 1'b1;
                end
            end
            MODE_TAG: begin
                res.byte_role = ROLE_TAG;
                if (i_code_byte == 8'd0) begin
                    n_st.list_ctx = LIST_NONE;
                    advance       = 1'b1;
                end else if (i_code_byte == 8'd1) begin
                    n_st.mode = MODE_STR;
                end else if (i_code_byte == 8'd2) begin
                    n_st.mode = MODE_EXPR;
                end else begin
                    res.error_code = ERR_TAG;
                end
            end
            MODE_STR: begin
                if (i_code_byte == 8'd0) begin
                    res.byte_role = ROLE_STR_END;
                    if (i_state.list_ctx == LIST_TWO) begin
                        n_st.mode = MODE_TAG;
                    end else begin
                        advance = 1'b1;
                    end
                end else begin
                    res.byte_role = ROLE_STR_CHAR;
                end
            end
            default: begin
                // Opcode byte: load the operand format queue.
                res.byte_role   = ROLE_OPCODE;
                n_st.list_ctx   = LIST_NONE;
                n_st.bytes_left = 3'd0;
                if (fm == FMT_UNKNOWN) begin
                    res.error_code = ERR_OPCODE;
                    n_st.fmt_queue = FMT_NONE;
                    n_st.mode      = MODE_OPCODE;
                    iend           = 1'b1;
                end else begin
                    n_st.fmt_queue = fm;
                    advance        = 1'b1;
                end
            end
        endcase

        // Start the next pending operand format, or end the instruction.
        if (advance) begin
            if (n_st.fmt_queue != FMT_NONE) begin
                nib            = n_st.fmt_queue[3:0];
                n_st.fmt_queue = {4'd0, n_st.fmt_queue[11:4]};
                case (nib)
                    NIB_U8: begin
                        n_st.mode       = MODE_IMM;
                        n_st.bytes_left = 3'd1;
                    end
                    NIB_U16: begin
                        n_st.mode       = MODE_IMM;
                        n_st.bytes_left = 3'd2;
                    end
                    NIB_U32: begin
                        n_st.mode       = MODE_IMM;
                        n_st.bytes_left = 3'd4;
                    end
                    NIB_EXPR: begin
                        n_st.mode = MODE_EXPR;
                    end
                    NIB_OFFSET: begin
                        n_st.mode         = MODE_OFFSET;
                        n_st.bytes_left   = 3'd4;
                        n_st.offset_accum = 32'd0;
                    end
                    NIB_LIST1: begin
                        n_st.list_ctx = LIST_ONE;
                        n_st.mode     = MODE_EXPR;
                    end
                    NIB_LIST2: begin
                        n_st.list_ctx = LIST_TWO;
                        n_st.mode     = MODE_TAG;
                    end
                    NIB_STR: begin
                        n_st.mode = MODE_STR;
                    end
                    default: begin
                        // The format table holds no other nibble values.
                        n_st.fmt_queue = FMT_NONE;
                        n_st.mode      = MODE_OPCODE;
                        n_st.list_ctx  = LIST_NONE;
                        iend           = 1'b1;
                    end
                endcase
            end else begin
                n_st.mode     = MODE_OPCODE;
                n_st.list_ctx = LIST_NONE;
                iend          = 1'b1;
            end
        end

        // The final byte of a stream returns the walker to its reset state.
        if (i_last_byte) begin
            if (!iend) begin
                res.error_code = ERR_TRUNC;
            end
            n_st = STATE_RESET;
        end

        res.instruction_end = iend;
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule

`default_nettype wire

// ===== hw/rtl/script_bytecode_operand_walker_core.sv =====
// ----------------------------------------------------------------------------
// Bytecode operand walker core
// Classifies each byte of a script code stream and reports offsets and errors.
// ----------------------------------------------------------------------------
// The block takes one code byte per clock while the output side does not
// stall, and returns one result transaction per byte, in order. A byte passes
// an input register and then a result register: the result register loads
// when the byte moves on from the input register, which holds the byte while
// the result register is full and stalled. The walker state is updated by
// combinational logic as each byte moves from the input register into the
// result register, which sets the sustained rate at one byte per cycle.
// Stalls on the output side propagate back through the input register
// without losing or repeating any transaction. A byte flagged as the last of
// a stream resets the walker, so the next byte starts a new stream at
// position zero.
`default_nettype none
`include "script_bytecode_operand_walker_core_defines.svh"

module script_bytecode_operand_walker_core
    import sbow_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_code_byte,
    input  wire logic        i_last_byte,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_byte_position,
    output logic [2:0]       o_byte_role,
    output logic             o_instruction_end,
    output logic             o_offset_done,
    output logic [31:0]      o_offset_target,
    output logic [2:0]       o_error_code
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_res;
    t_state     r_state;
    t_state     n_state;
    t_result    n_res;
    logic       out_free;
    logic       in_move;
    logic       in_accept;

    // Handshake: the result register frees when empty or taken.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_move    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Per-byte walker update.
    sbow_step u_step (
        .i_state     (r_state),
        .i_code_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_state     (n_state),
        .o_result    (n_res)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (in_move) begin
                r_in_valid <= 1'b0;
            end
            if (in_move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_code_byte;
            r_in_last <= i_last_byte;
        end
        if (in_move) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_position   = r_res.byte_position;
    assign o_byte_role       = r_res.byte_role;
    assign o_instruction_end = r_res.instruction_end;
    assign o_offset_done     = r_res.offset_done;
    assign o_offset_target   = r_res.offset_target;
    assign o_error_code      = r_res.error_code;

    // A transaction waiting in the input register is kept until it moves on.
    `SBOW_ASSERT_NEXT(a_in_held, r_in_valid && !out_free, r_in_valid,
        "input transaction dropped while the result register was full")

    // The end of a stream brings the position count back to zero.
    `SBOW_ASSERT_NEXT(a_stream_restart, in_move && r_in_last, r_state.position == 32'd0,
        "position not cleared after the last byte of a stream")

    // A truncated stream never reports a completed instruction.
    `SBOW_ASSERT_NOW(a_trunc_no_end, r_out_valid && (r_res.error_code == ERR_TRUNC),
        !r_res.instruction_end, "truncation reported on a completed instruction")

    // Only an offset byte can complete an offset operand.
    `SBOW_ASSERT_NOW(a_offset_role, r_out_valid && r_res.offset_done,
        r_res.byte_role == ROLE_OFFSET, "offset completion on a byte of another role")

    // The offset value is zero unless an offset completes.
    `SBOW_ASSERT_NOW(a_target_zero, r_out_valid && !r_res.offset_done,
        r_res.offset_target == 32'd0, "offset target set without a completed offset")

endmodule

`default_nettype wire

// ===== tb/tb_script_bytecode_operand_walker_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the bytecode operand walker core
// Feeds directed and random script byte streams through the walker. A local
// walker model predicts the position, role, instruction end, offset and error
// of every byte, and a checker compares each result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_script_bytecode_operand_walker_core;
    import sbow_pkg::*;

    // Opcodes used by the directed streams, named by their operand formats.
    localparam logic [7:0] OP_NO_ARGS    = 8'h00;
    localparam logic [7:0] OP_STR        = 8'h01;
    localparam logic [7:0] OP_EXPR_LIST1 = 8'h05;
    localparam logic [7:0] OP_OFFSET     = 8'h0C;
    localparam logic [7:0] OP_LIST2      = 8'h0E;
    localparam logic [7:0] OP_U8         = 8'h13;
    localparam logic [7:0] OP_UNKNOWN    = 8'hFE;

    // Expression tokens that carry raw operand bytes.
    localparam logic [7:0] TOK_SKIP1_80 = 8'h80;
    localparam logic [7:0] TOK_SKIP1_A0 = 8'hA0;
    localparam logic [7:0] TOK_SKIP1_C0 = 8'hC0;
    localparam logic [7:0] TOK_SKIP1_F8 = 8'hF8;
    localparam logic [7:0] TOK_SKIP1_F9 = 8'hF9;
    localparam logic [7:0] TOK_SKIP2_F1 = 8'hF1;
    localparam logic [7:0] TOK_SKIP2_F3 = 8'hF3;
    localparam logic [7:0] TOK_SKIP2_F6 = 8'hF6;
    localparam logic [7:0] TOK_SKIP4_F2 = 8'hF2;

    // List separators, list tags and the string terminator.
    localparam logic [7:0] SEP_LAST  = 8'h00;
    localparam logic [7:0] SEP_MORE  = 8'h01;
    localparam logic [7:0] TAG_END   = 8'h00;
    localparam logic [7:0] TAG_STR   = 8'h01;
    localparam logic [7:0] TAG_EXPR  = 8'h02;
    localparam logic [7:0] STR_END   = 8'h00;

    // Cumulative item counts at which each random phase stops.
    localparam int unsigned WELLFORMED_UNTIL = 1100;
    localparam int unsigned BURST_UNTIL      = 1300;
    localparam int unsigned NOISE_UNTIL      = 1550;
    localparam int unsigned MAX_REPORTS      = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_code_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_byte_position;
    logic [2:0]  o_byte_role;
    logic        o_instruction_end;
    logic        o_offset_done;
    logic [31:0] o_offset_target;
    logic [2:0]  o_error_code;

    script_bytecode_operand_walker_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_code_byte       (i_code_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_byte_position   (o_byte_position),
        .o_byte_role       (o_byte_role),
        .o_instruction_end (o_instruction_end),
        .o_offset_done     (o_offset_done),
        .o_offset_target   (o_offset_target),
        .o_error_code      (o_error_code)
    );

    always #10 i_clk = ~i_clk;

    // Walker model state.
    logic [31:0] w_pos;
    logic [11:0] w_fmts;
    logic [2:0]  w_mode;
    logic [2:0]  w_left;
    logic [31:0] w_accum;
    logic [1:0]  w_list;

    t_result     expected_results[$];
    logic [7:0]  stream_bytes[$];
    int unsigned items_sent;
    int unsigned error_count;
    bit          calm_mode;

    logic [7:0] known_opcodes [26] = '{
        8'h00, 8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0B,
        8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15,
        8'h16, 8'h17, 8'h1B, 8'h1C, 8'h1D, 8'h1F
    };

    logic [7:0] skip_tokens [9] = '{
        TOK_SKIP1_80, TOK_SKIP1_A0, TOK_SKIP1_C0, TOK_SKIP1_F8, TOK_SKIP1_F9,
        TOK_SKIP2_F1, TOK_SKIP2_F3, TOK_SKIP2_F6, TOK_SKIP4_F2
    };

    // Operand format queue of each opcode, next format in the low nibble.
    function automatic logic [11:0] formats_of(input logic [7:0] op);
        case (op)
            8'h00:                      return FMT_NONE;
            8'h13:                      return FMT_U8;
            8'h01:                      return FMT_STR;
            8'h04, 8'h16:               return FMT_U8_LIST1;
            8'h03, 8'h09:               return FMT_U16_LIST1;
            8'h05:                      return FMT_EXPR_LIST1;
            8'h06, 8'h07, 8'h08:        return FMT_EXPR_LIST1_U8;
            8'h0B, 8'h14, 8'h1C:        return FMT_EXPR_OFFS;
            8'h10:                      return FMT_LIST2_OFFS;
            8'h0C:                      return FMT_OFFS;
            8'h0D:                      return FMT_EXPR_LIST2;
            8'h0E, 8'h0F, 8'h11, 8'h12,
            8'h15, 8'h1B, 8'h1D:        return FMT_LIST2;
            8'h17, 8'h1F:               return FMT_U32;
            default:                    return FMT_UNKNOWN;
        endcase
    endfunction

    // Number of raw bytes that follow an expression token.
    function automatic logic [2:0] token_skip(input logic [7:0] tok);
        case (tok)
            TOK_SKIP1_80, TOK_SKIP1_A0, TOK_SKIP1_C0,
            TOK_SKIP1_F8, TOK_SKIP1_F9:               return 3'd1;
            TOK_SKIP2_F1, TOK_SKIP2_F3, TOK_SKIP2_F6: return 3'd2;
            TOK_SKIP4_F2:                             return 3'd4;
            default:                                  return 3'd0;
        endcase
    endfunction

    // At least half of the waits are zero so that back-to-back traffic is common.
    function automatic int unsigned pick_wait();
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic reset_walker();
        w_pos   = '0;
        w_fmts  = FMT_NONE;
        w_mode  = MODE_OPCODE;
        w_left  = '0;
        w_accum = '0;
        w_list  = LIST_NONE;
    endtask

    // Pops formats until one starts; an empty queue ends the instruction.
    task automatic start_next_format(output logic iend);
        logic [3:0] nib;
        bit         started;
        started = 1'b0;
        iend    = 1'b0;
        while (w_fmts != FMT_NONE && !started) begin
            nib     = w_fmts[3:0];
            w_fmts  = w_fmts >> 4;
            started = 1'b1;
            case (nib)
                NIB_U8:     begin w_mode = MODE_IMM; w_left = 3'd1; end
                NIB_U16:    begin w_mode = MODE_IMM; w_left = 3'd2; end
                NIB_U32:    begin w_mode = MODE_IMM; w_left = 3'd4; end
                NIB_EXPR:   w_mode = MODE_EXPR;
                NIB_OFFSET: begin
                    w_mode  = MODE_OFFSET;
                    w_left  = 3'd4;
                    w_accum = '0;
                end
                NIB_LIST1:  begin w_list = LIST_ONE; w_mode = MODE_EXPR; end
                NIB_LIST2:  begin w_list = LIST_TWO; w_mode = MODE_TAG; end
                NIB_STR:    w_mode = MODE_STR;
                default:    started = 1'b0;
            endcase
        end
        if (!started) begin
            w_mode = MODE_OPCODE;
            w_list = LIST_NONE;
            iend   = 1'b1;
        end
    endtask

    // A finished expression or string returns to its list, or moves on.
    task automatic finish_element(input bit was_expr, output logic iend);
        iend = 1'b0;
        if (w_list == LIST_ONE && was_expr)
            w_mode = MODE_SEP;
        else if (w_list == LIST_TWO)
            w_mode = MODE_TAG;
        else
            start_next_format(iend);
    endtask

    // Predicts the result of one byte and advances the walker model.
    task automatic walk_byte(input logic [7:0] code, input logic last,
                             output t_result res);
        logic [2:0]  role;
        logic [2:0]  err;
        logic [31:0] target;
        logic        iend;
        logic        odone;
        logic [11:0] fm;
        logic [2:0]  skip;
        int unsigned idx;
        role   = ROLE_OPCODE;
        err    = ERR_NONE;
        target = '0;
        iend   = 1'b0;
        odone  = 1'b0;
        res.byte_position = w_pos;
        w_pos = w_pos + 32'd1;
        case (w_mode)
            MODE_IMM: begin
                role = ROLE_IMM;
                if (w_left > 3'd1) begin
                    w_left = w_left - 3'd1;
                end else begin
                    w_left = '0;
                    start_next_format(iend);
                end
            end
            MODE_EXPR: begin
                if (code == BYTE_EXPR_END) begin
                    role = ROLE_EXPR_END;
                    finish_element(1'b1, iend);
                end else begin
                    role = ROLE_EXPR;
                    skip = token_skip(code);
                    if (skip != 3'd0) begin
                        w_left = skip;
                        w_mode = MODE_TOKARG;
                    end
                end
            end
            MODE_TOKARG: begin
                role = ROLE_EXPR;
                if (w_left > 3'd1) begin
                    w_left = w_left - 3'd1;
                end else begin
                    w_left = '0;
                    w_mode = MODE_EXPR;
                end
            end
            MODE_OFFSET: begin
                role    = ROLE_OFFSET;
                idx     = (4 - int'(w_left)) & 3;
                w_accum = w_accum | (32'(code) << (8 * idx));
                if (w_left > 3'd1) begin
                    w_left = w_left - 3'd1;
                end else begin
                    w_left = '0;
                    odone  = 1'b1;
                    target = w_accum;
                    start_next_format(iend);
                end
            end
            MODE_SEP: begin
                role = ROLE_TAG;
                if (code > SEP_MORE)
                    err = ERR_SEP;
                if (code != SEP_LAST) begin
                    w_mode = MODE_EXPR;
                end else begin
                    w_list = LIST_NONE;
                    start_next_format(iend);
                end
            end
            MODE_TAG: begin
                role = ROLE_TAG;
                if (code == TAG_END) begin
                    w_list = LIST_NONE;
                    start_next_format(iend);
                end else if (code == TAG_STR) begin
                    w_mode = MODE_STR;
                end else if (code == TAG_EXPR) begin
                    w_mode = MODE_EXPR;
                end else begin
                    err = ERR_TAG;
                end
            end
            MODE_STR: begin
                if (code == STR_END) begin
                    role = ROLE_STR_END;
                    finish_element(1'b0, iend);
                end else begin
                    role = ROLE_STR_CHAR;
                end
            end
            default: begin
                fm     = formats_of(code);
                role   = ROLE_OPCODE;
                w_list = LIST_NONE;
                w_left = '0;
                if (fm == FMT_UNKNOWN) begin
                    err    = ERR_OPCODE;
                    w_fmts = FMT_NONE;
                    w_mode = MODE_OPCODE;
                    iend   = 1'b1;
                end else begin
                    w_fmts = fm;
                    start_next_format(iend);
                end
            end
        endcase
        // The last byte of a stream flags an open instruction and restarts.
        if (last) begin
            if (!iend)
                err = ERR_TRUNC;
            reset_walker();
        end
        res.byte_role       = role;
        res.instruction_end = iend;
        res.offset_done     = odone;
        res.offset_target   = target;
        res.error_code      = err;
    endtask

    // Sends one byte after a random gap and records its expected result.
    task automatic send_byte(input logic [7:0] code, input logic last);
        int unsigned gap;
        t_result     res;
        gap = calm_mode ? 0 : pick_wait();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_code_byte <= code;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        walk_byte(code, last, res);
        expected_results.push_back(res);
        items_sent++;
    endtask

    // Sends the built stream, marking its final byte, and clears it.
    task automatic send_stream();
        foreach (stream_bytes[i])
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        stream_bytes.delete();
    endtask

    // Holds the input side idle until every expected result has arrived.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Appends an expression: random tokens with their raw bytes, then the end.
    task automatic add_expr();
        int unsigned n;
        logic [7:0]  tok;
        n = $urandom_range(0, 4);
        repeat (n) begin
            if ($urandom_range(0, 2) == 0) begin
                tok = skip_tokens[$urandom_range(0, 8)];
            end else begin
                do tok = 8'($urandom); while (tok == BYTE_EXPR_END);
            end
            stream_bytes.push_back(tok);
            repeat (token_skip(tok)) stream_bytes.push_back(8'($urandom));
        end
        stream_bytes.push_back(BYTE_EXPR_END);
    endtask

    task automatic add_string();
        repeat ($urandom_range(0, 5)) stream_bytes.push_back(8'($urandom_range(1, 255)));
        stream_bytes.push_back(STR_END);
    endtask

    // Appends one instruction with operands that follow its format queue.
    task automatic add_instruction(input logic [7:0] op);
        logic [11:0] fm;
        logic [3:0]  nib;
        int unsigned n;
        int unsigned raw;
        int unsigned pick;
        fm = formats_of(op);
        stream_bytes.push_back(op);
        if (fm == FMT_UNKNOWN)
            fm = FMT_NONE;
        while (fm != FMT_NONE) begin
            nib = fm[3:0];
            fm  = fm >> 4;
            raw = 0;
            case (nib)
                NIB_U8:             raw = 1;
                NIB_U16:            raw = 2;
                NIB_U32, NIB_OFFSET: raw = 4;
                NIB_EXPR:           add_expr();
                NIB_STR:            add_string();
                NIB_LIST1: begin
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) begin
                        add_expr();
                        if (i == n - 1)
                            stream_bytes.push_back(SEP_LAST);
                        else if ($urandom_range(0, 5) == 0)
                            stream_bytes.push_back(8'($urandom_range(2, 255)));
                        else
                            stream_bytes.push_back(SEP_MORE);
                    end
                end
                NIB_LIST2: begin
                    repeat ($urandom_range(0, 3)) begin
                        pick = $urandom_range(0, 9);
                        if (pick < 4) begin
                            stream_bytes.push_back(TAG_STR);
                            add_string();
                        end else if (pick < 8) begin
                            stream_bytes.push_back(TAG_EXPR);
                            add_expr();
                        end else begin
                            stream_bytes.push_back(8'($urandom_range(3, 255)));
                        end
                    end
                    stream_bytes.push_back(TAG_END);
                end
                default: ;
            endcase
            repeat (raw) stream_bytes.push_back(8'($urandom));
        end
    endtask

    // Mostly known opcodes, with an occasional unknown one.
    function automatic logic [7:0] pick_opcode();
        logic [7:0] op;
        if ($urandom_range(0, 9) != 0)
            return known_opcodes[$urandom_range(0, 25)];
        do op = 8'($urandom); while (formats_of(op) != FMT_UNKNOWN);
        return op;
    endfunction

    // Extremes of the fields and each error and end-of-stream case.
    task automatic test_directed_cases();
        // An opcode without operands that is also the last byte.
        stream_bytes = '{OP_NO_ARGS};
        send_stream();
        // An unknown opcode, then an immediate at its maximum.
        stream_bytes = '{OP_UNKNOWN, OP_U8, 8'hFF, OP_NO_ARGS};
        send_stream();
        // An offset of all ones that completes at the end of the stream.
        stream_bytes = '{OP_OFFSET, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_stream();
        // A four-byte token, then a list1 with a bad separator.
        stream_bytes = '{OP_EXPR_LIST1, TOK_SKIP4_F2, 8'h11, 8'h22, 8'h33,
                         BYTE_EXPR_END, BYTE_EXPR_END, BYTE_EXPR_END, 8'h02,
                         BYTE_EXPR_END, SEP_LAST};
        send_stream();
        // A bad list2 tag, then truncation inside a string.
        stream_bytes = '{OP_LIST2, 8'h07, TAG_STR, 8'h41};
        send_stream();
        // Truncation on a bad tag wins over the tag error.
        stream_bytes = '{OP_LIST2, 8'h09};
        send_stream();
        // An offset with distinct bytes checks the byte order.
        stream_bytes = '{OP_OFFSET, 8'h78, 8'h56, 8'h34, 8'h12, OP_STR, STR_END};
        send_stream();
        drain_results();
    endtask

    // Streams that follow the operand formats, with random content and occasional bad bytes, some cut short.
    task automatic test_wellformed_streams();
        int unsigned n_instr;
        int unsigned cut;
        int unsigned next_pause;
        next_pause = items_sent + 300;
        while (items_sent < WELLFORMED_UNTIL) begin
            if ($urandom_range(0, 9) == 0)
                n_instr = $urandom_range(20, 40);
            else
                n_instr = $urandom_range(1, 8);
            repeat (n_instr) add_instruction(pick_opcode());
            if ($urandom_range(0, 6) == 0) begin
                cut = $urandom_range(1, stream_bytes.size());
                stream_bytes = stream_bytes[0:cut-1];
            end
            send_stream();
            if (items_sent >= next_pause) begin
                drain_results();
                next_pause = items_sent + 300;
            end
        end
        drain_results();
    endtask

    // Back-to-back streams with neither side idling.
    task automatic test_idle_free_burst();
        calm_mode = 1'b1;
        while (items_sent < BURST_UNTIL) begin
            repeat ($urandom_range(1, 10)) add_instruction(pick_opcode());
            send_stream();
        end
        drain_results();
        calm_mode = 1'b0;
    endtask

    // Unstructured bytes with random stream ends.
    task automatic test_random_noise();
        while (items_sent < NOISE_UNTIL)
            send_byte(8'($urandom), $urandom_range(0, 15) == 0);
        drain_results();
    endtask

    // Output side stall: a random hold-off before each result transaction.
    initial begin
        int unsigned hold;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = calm_mode ? 0 : pick_wait();
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk);
            while (!(i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0));
        end
    end

    // Compares each accepted result transaction with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with none expected, pos %h role %0d",
                             $realtime, o_byte_position, o_byte_role);
            end else begin
                want = expected_results.pop_front();
                if (o_byte_position !== want.byte_position ||
                    o_byte_role !== want.byte_role ||
                    o_instruction_end !== want.instruction_end ||
                    o_offset_done !== want.offset_done ||
                    o_offset_target !== want.offset_target ||
                    o_error_code !== want.error_code) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch exp pos %h role %0d end %0b done %0b target %h err %0d",
                                 $realtime,
                                 want.byte_position, want.byte_role, want.instruction_end,
                                 want.offset_done, want.offset_target, want.error_code);
                        $display("%0t:          got pos %h role %0d end %0b done %0b target %h err %0d",
                                 $realtime,
                                 o_byte_position, o_byte_role, o_instruction_end,
                                 o_offset_done, o_offset_target, o_error_code);
                    end
                end
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Reset, the tests in turn, and the final verdict.
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_code_byte <= 8'h00;
        i_last_byte <= 1'b0;
        calm_mode    = 1'b0;
        items_sent   = 0;
        error_count  = 0;
        reset_walker();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_wellformed_streams();
        test_idle_free_burst();
        test_random_noise();

        // Let any stray result show up before the verdict.
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
